>>> rtl/hptt_pkg.sv
// shared widths, row layout and decision codes for the hashed page table translator
package hptt_pkg;

    localparam int VA_BITS          = 48;
    localparam int PAGE_OFFSET_BITS = 21;
    localparam int BUCKET_BITS      = 10;
    localparam int LINE_INDEX_BITS  = 11;
    localparam int PA_PAGE_BITS     = 27;
    localparam int ENTRIES_PER_LINE = 8;

    localparam int ADDR_W     = 48;
    localparam int TAG_W      = VA_BITS - PAGE_OFFSET_BITS - BUCKET_BITS;
    localparam int LINE_COUNT = 1 << LINE_INDEX_BITS;
    localparam int NFL_W      = LINE_INDEX_BITS + 1;
    localparam int ENTRY_W    = TAG_W + PA_PAGE_BITS;
    localparam int ROW_W      = ENTRIES_PER_LINE * ENTRY_W + LINE_INDEX_BITS;
    localparam int LINK_LSB   = ENTRIES_PER_LINE * ENTRY_W;
    localparam int EIDX_W     = (ENTRIES_PER_LINE > 1) ? $clog2(ENTRIES_PER_LINE) : 1;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = ((2 * ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((1 + ADDR_W + STATUS_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        DEC_HIT,
        DEC_MISS,
        DEC_INSERT,
        DEC_NEXT,
        DEC_ALLOC,
        DEC_FULL
    } decision_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic step;
        logic write_cur;
        logic alloc;
        logic load_result;
    } ctrl_t;

    typedef struct packed {
        logic      clear_last;
        logic      out_free;
        decision_t decision;
    } stat_t;

endpackage

>>> rtl/hptt_ram.sv
// generic simple dual-port ram with registered read
module hptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hptt_datapath.sv
// datapath: request registers, line memory, chain decision and result register
module hptt_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hptt_pkg::ctrl_t               ctrl,
    output hptt_pkg::stat_t               stat,
    input  logic [hptt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hptt_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int LW = hptt_pkg::LINE_INDEX_BITS;

    logic                                  cmd_reg;
    logic [hptt_pkg::TAG_W-1:0]            tag_reg;
    logic [hptt_pkg::PAGE_OFFSET_BITS-1:0] offset_reg;
    logic [hptt_pkg::PA_PAGE_BITS-1:0]     page_reg;
    logic [LW-1:0]                         line_reg;
    logic [hptt_pkg::NFL_W-1:0]            nfl_reg;
    logic [LW-1:0]                         clr_reg;
    logic                                  out_valid_reg;
    logic [hptt_pkg::M_DATA_W-1:0]         out_data_reg;

    logic [hptt_pkg::ADDR_W-1:0]   va;
    logic [hptt_pkg::ADDR_W-1:0]   pa;
    logic [hptt_pkg::ROW_W-1:0]    rdata;
    logic [hptt_pkg::ROW_W-1:0]    wdata;
    logic [hptt_pkg::ROW_W-1:0]    row_mod;
    logic [hptt_pkg::ROW_W-1:0]    row_new;
    logic [LW-1:0]                 waddr;
    logic [LW-1:0]                 raddr;
    logic [LW-1:0]                 link;
    logic                          we;
    logic                          re;
    logic                          stop_found;
    logic                          stop_match;
    logic [hptt_pkg::EIDX_W-1:0]   stop_idx;
    logic                          empty_found;
    logic [hptt_pkg::EIDX_W-1:0]   empty_idx;
    hptt_pkg::decision_t           decision;
    logic                          r_found;
    logic [hptt_pkg::ADDR_W-1:0]   r_addr;
    logic [hptt_pkg::STATUS_W-1:0] r_status;

    assign va   = s_tdata[hptt_pkg::ADDR_W-1:0];
    assign pa   = s_tdata[2*hptt_pkg::ADDR_W-1:hptt_pkg::ADDR_W];
    assign link = rdata[hptt_pkg::LINK_LSB +: LW];

    always_comb begin
        logic [hptt_pkg::TAG_W-1:0] et;
        stop_found  = 1'b0;
        stop_match  = 1'b0;
        stop_idx    = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = hptt_pkg::ENTRIES_PER_LINE - 1; i >= 0; i--) begin
            et = rdata[i*hptt_pkg::ENTRY_W +: hptt_pkg::TAG_W];
            if (et == '0) begin
                empty_found = 1'b1;
                empty_idx   = hptt_pkg::EIDX_W'(i);
            end
            if (et == '0 || et == tag_reg) begin
                stop_found = 1'b1;
                stop_match = (et == tag_reg);
                stop_idx   = hptt_pkg::EIDX_W'(i);
            end
        end
    end

    always_comb begin
        if (tag_reg == '0) begin
            decision = hptt_pkg::DEC_MISS;
        end else if (!cmd_reg) begin
            if (stop_found) begin
                decision = stop_match ? hptt_pkg::DEC_HIT : hptt_pkg::DEC_MISS;
            end else if (link == '0) begin
                decision = hptt_pkg::DEC_MISS;
            end else begin
                decision = hptt_pkg::DEC_NEXT;
            end
        end else if (empty_found) begin
            decision = hptt_pkg::DEC_INSERT;
        end else if (link != '0) begin
            decision = hptt_pkg::DEC_NEXT;
        end else if (nfl_reg[hptt_pkg::NFL_W-1]) begin
            decision = hptt_pkg::DEC_FULL;
        end else begin
            decision = hptt_pkg::DEC_ALLOC;
        end
    end

    always_comb begin
        row_mod = rdata;
        if (decision == hptt_pkg::DEC_ALLOC) begin
            row_mod[hptt_pkg::LINK_LSB +: LW] = nfl_reg[LW-1:0];
        end else begin
            row_mod[empty_idx*hptt_pkg::ENTRY_W +: hptt_pkg::ENTRY_W] = {page_reg, tag_reg};
        end
        row_new = '0;
        row_new[hptt_pkg::ENTRY_W-1:0] = {page_reg, tag_reg};
    end

    always_comb begin
        we    = ctrl.clear | ctrl.write_cur | ctrl.alloc;
        waddr = line_reg;
        wdata = row_mod;
        if (ctrl.clear) begin
            waddr = clr_reg;
            wdata = '0;
        end else if (ctrl.alloc) begin
            waddr = nfl_reg[LW-1:0];
            wdata = row_new;
        end
        re    = ctrl.accept | ctrl.step;
        raddr = ctrl.accept
              ? LW'(va[hptt_pkg::PAGE_OFFSET_BITS +: hptt_pkg::BUCKET_BITS])
              : link;
    end

    hptt_ram #(
        .WIDTH(hptt_pkg::ROW_W),
        .DEPTH(hptt_pkg::LINE_COUNT)
    ) u_line_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        r_found  = 1'b0;
        r_addr   = '0;
        r_status = hptt_pkg::STATUS_MISS;
        unique case (decision)
            hptt_pkg::DEC_HIT: begin
                r_found  = 1'b1;
                r_addr   = hptt_pkg::ADDR_W'({rdata[stop_idx*hptt_pkg::ENTRY_W
                           + hptt_pkg::TAG_W +: hptt_pkg::PA_PAGE_BITS], offset_reg});
                r_status = hptt_pkg::STATUS_OK;
            end
            hptt_pkg::DEC_INSERT, hptt_pkg::DEC_ALLOC: begin
                r_found  = 1'b1;
                r_status = hptt_pkg::STATUS_OK;
            end
            hptt_pkg::DEC_FULL: r_status = hptt_pkg::STATUS_FULL;
            hptt_pkg::DEC_MISS, hptt_pkg::DEC_NEXT: r_status = hptt_pkg::STATUS_MISS;
            default: r_status = hptt_pkg::STATUS_MISS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nfl_reg       <= hptt_pkg::NFL_W'(1) << hptt_pkg::BUCKET_BITS;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctrl.alloc) begin
                nfl_reg <= nfl_reg + 1'b1;
            end
            if (ctrl.load_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            cmd_reg    <= s_tuser;
            tag_reg    <= va[hptt_pkg::PAGE_OFFSET_BITS + hptt_pkg::BUCKET_BITS +: hptt_pkg::TAG_W];
            offset_reg <= va[hptt_pkg::PAGE_OFFSET_BITS-1:0];
            page_reg   <= pa[hptt_pkg::PAGE_OFFSET_BITS +: hptt_pkg::PA_PAGE_BITS];
            line_reg   <= LW'(va[hptt_pkg::PAGE_OFFSET_BITS +: hptt_pkg::BUCKET_BITS]);
        end else if (ctrl.step) begin
            line_reg <= link;
        end
        if (ctrl.load_result) begin
            out_data_reg <= hptt_pkg::M_DATA_W'({r_status, r_addr, r_found});
        end
    end

    assign stat.clear_last = (clr_reg == {LW{1'b1}});
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.decision   = decision;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_result |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending transaction");
    a_alloc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.alloc |-> !nfl_reg[hptt_pkg::NFL_W-1])
        else $error("overflow line taken with none left");
    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.alloc |=> nfl_reg == $past(nfl_reg) + 1'b1)
        else $error("free line pointer did not advance");
`endif

endmodule

>>> rtl/hptt_controller.sv
// controller: clearing pass, request acceptance and chain walk sequencing
module hptt_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  hptt_pkg::stat_t stat,
    output hptt_pkg::ctrl_t ctrl
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_ALLOC = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctrl.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.accept = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.decision == hptt_pkg::DEC_NEXT) begin
                    ctrl.step = 1'b1;
                end else if (stat.out_free) begin
                    if (stat.decision == hptt_pkg::DEC_ALLOC) begin
                        ctrl.write_cur = 1'b1;
                        state_next     = ST_ALLOC;
                    end else begin
                        ctrl.write_cur   = (stat.decision == hptt_pkg::DEC_INSERT);
                        ctrl.load_result = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_ALLOC: begin
                ctrl.alloc       = 1'b1;
                ctrl.load_result = 1'b1;
                state_next       = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/hashed_page_table_translator_unit.sv
// top level of the hashed page table translator
// the slave channel carries one request per transaction: s_tuser selects
// lookup (0) or insert (1), s_tdata holds the virtual and physical address
// the master channel returns one result per request: found, translated
// address and status, packed in m_tdata
// the table lives in one line memory, a row per line with all its entries
// and the link to the next line, so each line of a chain is one read
// a request is accepted in the idle state, then each line that it visits
// is decided in the evaluate state; an insert that has to link a new
// overflow line also passes through the allocation state; a new request
// is accepted only in the idle state, once the walk of the last one ends
// after reset the block runs a clearing pass over all 2048 lines, one line
// per cycle, with s_tready low; then all entries are empty and no links exist
// a result waits in the output register while m_tready is low; the next
// request is still accepted; its walk holds before a write or result load
module hashed_page_table_translator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hptt_pkg::S_DATA_W-1:0] s_tdata,  // virtual_address, physical_address
    input  logic                          s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hptt_pkg::M_DATA_W-1:0] m_tdata   // found, translated_address, status
);

    hptt_pkg::ctrl_t ctrl;
    hptt_pkg::stat_t stat;

    hptt_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    hptt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
